### design/hcrvq_pkg.sv
// package for the two-stage hamming codebook search
// shared constants, queue item type and the chunk popcount helper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hcrvq_pkg;

  // codebook geometry
  localparam int CbDepthDefault = 256;
  localparam int WordW          = 64;
  localparam int VecW           = 4 * WordW;
  localparam int IdxW           = 8;

  // codebook size register
  localparam int SizeW     = 9;
  localparam int SizeReset = 1;

  // front to back queue
  localparam int QueueDepth = 2;

  // distance datapath: 8-bit chunks, summed in groups of eight
  localparam int ChunkW    = 8;
  localparam int NumChunks = VecW / ChunkW;
  localparam int GroupSize = 8;
  localparam int NumGroups = NumChunks / GroupSize;
  localparam int ChunkCntW = $clog2(ChunkW + 1);
  localparam int GroupSumW = $clog2(ChunkW * GroupSize + 1);
  localparam int DistW     = $clog2(VecW + 1);

  // distance that any real entry beats
  localparam logic [DistW-1:0] NoDistance = DistW'(32'hFFFF_FFFF);

  // classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_SKIP  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  entry_index;
    logic [VecW-1:0]  vec;
  } item_t;

  // ones count of one chunk
  function automatic logic [ChunkCntW-1:0] popcount8(input logic [ChunkW-1:0] x);
    logic [ChunkCntW-1:0] n;
    n = '0;
    for (int i = 0; i < ChunkW; i++) begin
      n = n + ChunkCntW'(x[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### design/hcrvq_if.sv
// valid/ready channels of the hamming codebook search
// input channel carries load or query beats, output channel carries results
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface hcrvq_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  entry_index;
  logic [63:0] vec_word0;
  logic [63:0] vec_word1;
  logic [63:0] vec_word2;
  logic [63:0] vec_word3;

  modport source (
    output valid, kind, entry_index, vec_word0, vec_word1, vec_word2, vec_word3,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_index, vec_word0, vec_word1, vec_word2, vec_word3,
    output ready
  );
endinterface

interface hcrvq_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  first_index;
  logic [7:0]  second_index;
  logic [63:0] recon_word0;
  logic [63:0] recon_word1;
  logic [63:0] recon_word2;
  logic [63:0] recon_word3;

  modport source (
    output valid, first_index, second_index,
    output recon_word0, recon_word1, recon_word2, recon_word3,
    input  ready
  );
  modport sink (
    input  valid, first_index, second_index,
    input  recon_word0, recon_word1, recon_word2, recon_word3,
    output ready
  );
endinterface

`default_nettype wire

### design/hcrvq_front.sv
// front end: accepts input beats and classifies them into queue items
// depends on hcrvq_pkg and hcrvq_in_if
`timescale 1ns / 1ps
`default_nettype none

module hcrvq_front
  import hcrvq_pkg::*;
#(
  parameter int CbDepth = CbDepthDefault
) (
  hcrvq_in_if.sink    in_i,
  input  wire logic   q_full_i,
  output      logic   push_o,
  output      item_t  push_item_o
);

  logic load_in_range;

  // accept whenever the queue has room
  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  // loads beyond the codebook are dropped by the back end
  assign load_in_range = 32'(in_i.entry_index) < CbDepth;

  always_comb begin
    push_item_o.entry_index = in_i.entry_index;
    push_item_o.vec = {in_i.vec_word3, in_i.vec_word2, in_i.vec_word1, in_i.vec_word0};
    if (in_i.kind) begin
      push_item_o.op = OP_QUERY;
    end else if (load_in_range) begin
      push_item_o.op = OP_LOAD;
    end else begin
      push_item_o.op = OP_SKIP;
    end
  end

endmodule

`default_nettype wire

### design/hcrvq_fifo.sv
// short queue of classified items between front and back end
// depends on hcrvq_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcrvq_fifo
  import hcrvq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t push_item_i,
  output      logic  full_o,
  output      logic  head_valid_o,
  output      item_t head_item_o,
  input  wire logic  pop_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t             slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o       = count_q == CntW'(QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_item_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### design/hcrvq_back.sv
// back end: codebook memory, two-pass nearest search pipeline, result register
// depends on hcrvq_pkg and hcrvq_out_if
`timescale 1ns / 1ps
`default_nettype none

module hcrvq_back
  import hcrvq_pkg::*;
#(
  parameter int CbDepth = CbDepthDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [$clog2(CbDepth + 1)-1:0]     active_size_i,
  input  wire logic                               head_valid_i,
  input  wire item_t                              head_item_i,
  output      logic                               pop_o,
  hcrvq_out_if.source                             out_o
);

  localparam int AddrW = (CbDepth > 1) ? $clog2(CbDepth) : 1;
  localparam int CntW  = $clog2(CbDepth + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]            state_q, state_d;
  logic                  pass_q;
  logic [CntW-1:0]       cnt_q;
  logic                  mem_we, rd_en, pass_start, pass_end, load_out;

  logic [VecW-1:0]       cb_mem [CbDepth];
  logic [VecW-1:0]       rdata_q;
  logic [VecW-1:0]       target_q;

  logic                  s0_valid_q, s1_valid_q, s2_valid_q;
  logic [AddrW-1:0]      s0_idx_q, s1_idx_q, s2_idx_q;
  logic [VecW-1:0]       s1_row_q, s2_row_q;
  logic [ChunkCntW-1:0]  s1_pc_q [NumChunks];
  logic [GroupSumW-1:0]  grp_sum [NumGroups];
  logic [GroupSumW-1:0]  s2_sum_q [NumGroups];
  logic [DistW-1:0]      ham_d;

  logic [DistW-1:0]      best_d_q;
  logic [AddrW-1:0]      best_idx_q;
  logic [VecW-1:0]       best_row_q;
  logic [AddrW-1:0]      first_idx_q;
  logic [VecW-1:0]       first_row_q;

  logic                  out_valid_q;
  logic [IdxW-1:0]       out_first_q, out_second_q;
  logic [VecW-1:0]       out_recon_q;

  // sequencer: loads, two scan passes, result hand-off
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    pass_start = 1'b0;
    pass_end   = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          unique case (head_item_i.op)
            OP_LOAD: begin
              mem_we = 1'b1;
            end
            OP_QUERY: begin
              pass_start = 1'b1;
              state_d    = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_q == active_size_i) begin
          state_d = ST_FLUSH;
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!s0_valid_q && !s1_valid_q && !s2_valid_q) begin
          pass_end = 1'b1;
          state_d  = pass_q ? ST_RESULT : ST_SCAN;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      cnt_q       <= '0;
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s0_valid_q <= rd_en;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      if (pass_start) begin
        pass_q <= 1'b0;
      end else if (pass_end) begin
        pass_q <= 1'b1;
      end
      if (pass_start || pass_end) begin
        cnt_q <= '0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // codebook memory, one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cb_mem[AddrW'(head_item_i.entry_index)] <= head_item_i.vec;
    end
    if (rd_en) begin
      rdata_q <= cb_mem[cnt_q[AddrW-1:0]];
    end
  end

  // group sums of the chunk counts
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_sum[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        grp_sum[g] = grp_sum[g] + GroupSumW'(s1_pc_q[g * GroupSize + k]);
      end
    end
  end

  // total distance of the entry in the last stage
  always_comb begin
    ham_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      ham_d = ham_d + DistW'(s2_sum_q[g]);
    end
  end

  // distance pipeline and running best
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s0_idx_q <= cnt_q[AddrW-1:0];
    end
    if (s0_valid_q) begin
      s1_idx_q <= s0_idx_q;
      s1_row_q <= rdata_q;
      for (int c = 0; c < NumChunks; c++) begin
        s1_pc_q[c] <= popcount8(rdata_q[c * ChunkW +: ChunkW] ^ target_q[c * ChunkW +: ChunkW]);
      end
    end
    if (s1_valid_q) begin
      s2_idx_q <= s1_idx_q;
      s2_row_q <= s1_row_q;
      s2_sum_q <= grp_sum;
    end

    // strict compare keeps the lowest index on ties
    if (pass_start || (pass_end && !pass_q)) begin
      best_d_q   <= NoDistance;
      best_idx_q <= '0;
      best_row_q <= '0;
    end else if (s2_valid_q && (ham_d < best_d_q)) begin
      best_d_q   <= ham_d;
      best_idx_q <= s2_idx_q;
      best_row_q <= s2_row_q;
    end

    // query target, then residual for the second pass
    if (pass_start) begin
      target_q <= head_item_i.vec;
    end else if (pass_end && !pass_q) begin
      target_q <= target_q ^ best_row_q;
    end
    if (pass_end && !pass_q) begin
      first_idx_q <= best_idx_q;
      first_row_q <= best_row_q;
    end

    // result register
    if (load_out) begin
      out_first_q  <= IdxW'(first_idx_q);
      out_second_q <= IdxW'(best_idx_q);
      out_recon_q  <= first_row_q ^ best_row_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.first_index  = out_first_q;
  assign out_o.second_index = out_second_q;
  assign out_o.recon_word0  = out_recon_q[0 * WordW +: WordW];
  assign out_o.recon_word1  = out_recon_q[1 * WordW +: WordW];
  assign out_o.recon_word2  = out_recon_q[2 * WordW +: WordW];
  assign out_o.recon_word3  = out_recon_q[3 * WordW +: WordW];

endmodule

`default_nettype wire

### design/hamming_codebook_rvq_search.sv
// timing: a load is written when the idle back end pops it from the queue; a query result turns
//   valid after two scan passes over size entries, size being the saturated codebook_size
// each pass reads the codebook memory through its single read port, one entry a cycle, and then
//   drains the pipeline; the back end pops no new item until a query's result is registered
// reset: control and queue cleared, codebook_size back to 1, memory left as is
`timescale 1ns / 1ps
`default_nettype none

module hamming_codebook_rvq_search
  import hcrvq_pkg::*;
#(
  parameter int CbDepth = CbDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [SizeW-1:0] cfg_wdata_i,
  hcrvq_in_if.sink              in_i,
  hcrvq_out_if.source           out_o
);

  localparam int CntW = $clog2(CbDepth + 1);
  localparam int SatW = (CntW > SizeW) ? CntW : SizeW;

  logic [SizeW-1:0] size_q;
  logic [SatW-1:0]  size_ext;
  logic [CntW-1:0]  active_size;
  logic             q_full, push, head_valid, pop;
  item_t            push_item, head_item;

  // codebook size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(SizeReset);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // saturate to the memory depth
  assign size_ext    = SatW'(size_q);
  assign active_size = (size_ext > SatW'(CbDepth)) ? CntW'(CbDepth) : CntW'(size_ext);

  hcrvq_front #(
    .CbDepth (CbDepth)
  ) u_front (
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  hcrvq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .pop_i        (pop)
  );

  hcrvq_back #(
    .CbDepth (CbDepth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_size_i (active_size),
    .head_valid_i  (head_valid),
    .head_item_i   (head_item),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule

`default_nettype wire
